// ===== src/pthf_pkg.sv =====
// Package: shared constants for the threshold pulse hit finder.
package pthf_pkg;

    // Field widths
    localparam int SAMPLE_BITS  = 16;
    localparam int INDEX_BITS   = 12;
    localparam int LENGTH_BITS  = 13;
    localparam int CHARGE_BITS  = 32;
    localparam int QUIET_BITS   = 4;
    localparam int CFG_IDX_BITS = 1;
    localparam int CFG_DATA_BITS = 16;

    // Default waveform length limit
    localparam int MAX_SAMPLES_DEF = 4096;

    // Samples summed ahead of the opening sample
    localparam int PRE_SAMPLES = 2;

    // Quiet-run counter saturation value
    localparam logic [QUIET_BITS-1:0] QUIET_MAX = 4'd15;

    // Register reset values
    localparam logic signed [SAMPLE_BITS-1:0] THRESHOLD_RST    = '0;
    localparam logic [QUIET_BITS-1:0]         QUIET_LENGTH_RST = 4'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD    = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_QUIET_LENGTH = 1'd1;

endpackage

// ===== src/pulse_threshold_hit_finder_core.sv =====
// Top level: threshold pulse hit finder, one sample per cycle while no hit waits on m_ready.
//
// Takes one waveform sample per transaction and reports a hit transaction on
// the sample that closes it: opening index, start index (two samples earlier,
// floored at zero), length and 32-bit wrapping charge. The block sustains one
// sample per clock; a sample goes through an input register and the hit logic
// into a result register, which presents each hit on m_valid. The result
// register is the only thing that can hold the input back: while a hit waits
// on m_ready, the sample behind it stalls.
// Configuration writes (threshold, quiet length) are to be made while idle.
module pulse_threshold_hit_finder_core #(
    parameter int MAX_SAMPLES = pthf_pkg::MAX_SAMPLES_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    // configuration write port
    input  logic                                     cfg_wr_en,
    input  logic [pthf_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [pthf_pkg::CFG_DATA_BITS-1:0]       cfg_data,
    // sample input
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [pthf_pkg::SAMPLE_BITS-1:0]  s_sample,
    input  logic                                     s_waveform_last,
    // hit output
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic [pthf_pkg::INDEX_BITS-1:0]          m_cross_index,
    output logic [pthf_pkg::INDEX_BITS-1:0]          m_start_index,
    output logic [pthf_pkg::LENGTH_BITS-1:0]         m_length,
    output logic signed [pthf_pkg::CHARGE_BITS-1:0]  m_charge
);

    localparam int SB    = pthf_pkg::SAMPLE_BITS;
    localparam int CB    = pthf_pkg::CHARGE_BITS;
    localparam int QB    = pthf_pkg::QUIET_BITS;
    localparam int IB    = pthf_pkg::INDEX_BITS;
    localparam int LB    = pthf_pkg::LENGTH_BITS;
    localparam int IDX_W = $clog2(MAX_SAMPLES);
    localparam logic [IDX_W:0]   MAX_W = (IDX_W+1)'(MAX_SAMPLES);
    localparam logic [IDX_W-1:0] PRE_W = IDX_W'(pthf_pkg::PRE_SAMPLES);

    // Configuration registers
    logic signed [SB-1:0] threshold_reg;
    logic [QB-1:0]        quiet_length_reg;

    // Input register
    logic                 in_vld_reg;
    logic signed [SB-1:0] in_sample_reg;
    logic                 in_last_reg;

    // Hit state
    logic [IDX_W-1:0]     count_reg, count_next;
    logic signed [SB-1:0] hist0_reg, hist0_next;
    logic signed [SB-1:0] hist1_reg, hist1_next;
    logic                 hit_open_reg, hit_open_next;
    logic [QB-1:0]        quiet_reg, quiet_next;
    logic [CB-1:0]        charge_reg, charge_next;
    logic [IDX_W-1:0]     open_idx_reg, open_idx_next;
    logic [IDX_W-1:0]     first_idx_reg, first_idx_next;
    logic                 skip_reg, skip_next;

    // Result register
    logic                 out_vld_reg;
    logic [IB-1:0]        out_cross_reg;
    logic [IB-1:0]        out_start_reg;
    logic [LB-1:0]        out_length_reg;
    logic [CB-1:0]        out_charge_reg;

    // Hit logic intermediates
    logic                 advance;
    logic                 open_now, track, above, quiet_close, emit;
    logic [QB-1:0]        q_base, q_new;
    logic [CB-1:0]        charge_base, sample_ext;
    logic [IDX_W-1:0]     open_use, first_use, first_at_open;
    logic [IDX_W:0]       count_inc, span;
    logic [IB+IDX_W-1:0]  cross_ext, start_ext;
    logic [LB+IDX_W:0]    len_ext;

    // Handshake: process the held sample when the result slot is free
    assign advance = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= pthf_pkg::THRESHOLD_RST;
            quiet_length_reg <= pthf_pkg::QUIET_LENGTH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                pthf_pkg::CFG_THRESHOLD:    threshold_reg    <= SB'(cfg_data);
                pthf_pkg::CFG_QUIET_LENGTH: quiet_length_reg <= QB'(cfg_data);
                default: ;
            endcase
        end
    end

    // Capture the input transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_sample_reg <= s_sample;
            in_last_reg   <= s_waveform_last;
        end
    end

    // Hit detection, quiet-run tracking and charge accumulation
    always_comb begin
        sample_ext = CB'(in_sample_reg);
        open_now   = !hit_open_reg && !skip_reg && (in_sample_reg >= threshold_reg);
        track      = hit_open_reg || open_now;
        above      = in_sample_reg > threshold_reg;

        // seed the sum with the two previous samples on opening
        charge_base = hit_open_reg ? charge_reg : (CB'(hist0_reg) + CB'(hist1_reg));

        q_base = hit_open_reg ? quiet_reg : '0;
        if (above) begin
            q_new = '0;
        end else if (q_base < pthf_pkg::QUIET_MAX) begin
            q_new = q_base + 1'b1;
        end else begin
            q_new = q_base;
        end
        quiet_close = q_new >= quiet_length_reg;
        emit        = track && (quiet_close || in_last_reg);

        first_at_open = (count_reg >= PRE_W) ? (count_reg - PRE_W) : '0;
        open_use      = open_now ? count_reg : open_idx_reg;
        first_use     = open_now ? first_at_open : first_idx_reg;

        // window length modulo the index range
        if (count_reg >= first_use) begin
            span = {1'b0, count_reg} - {1'b0, first_use};
        end else begin
            span = {1'b0, count_reg} + MAX_W - {1'b0, first_use};
        end
        len_ext   = {{LB{1'b0}}, span} + 1'b1;
        cross_ext = {{IB{1'b0}}, open_use};
        start_ext = {{IB{1'b0}}, first_use};

        // advance the index with wrap at the limit
        count_inc = {1'b0, count_reg} + 1'b1;

        // default next state
        charge_next    = track ? (charge_base + sample_ext) : charge_reg;
        open_idx_next  = open_use;
        first_idx_next = first_use;
        hist1_next     = hist0_reg;
        hist0_next     = in_sample_reg;
        count_next     = (count_inc >= MAX_W) ? '0 : count_inc[IDX_W-1:0];
        skip_next      = emit && quiet_close;
        if (emit) begin
            hit_open_next = 1'b0;
            quiet_next    = '0;
        end else if (track) begin
            hit_open_next = 1'b1;
            quiet_next    = q_new;
        end else begin
            hit_open_next = hit_open_reg;
            quiet_next    = quiet_reg;
        end

        // drop per-waveform state at the end of the waveform
        if (in_last_reg) begin
            count_next    = '0;
            hist0_next    = '0;
            hist1_next    = '0;
            hit_open_next = 1'b0;
            quiet_next    = '0;
            skip_next     = 1'b0;
        end
    end

    // Hold hit state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            hist0_reg     <= '0;
            hist1_reg     <= '0;
            hit_open_reg  <= 1'b0;
            quiet_reg     <= '0;
            charge_reg    <= '0;
            open_idx_reg  <= '0;
            first_idx_reg <= '0;
            skip_reg      <= 1'b0;
        end else if (advance) begin
            count_reg     <= count_next;
            hist0_reg     <= hist0_next;
            hist1_reg     <= hist1_next;
            hit_open_reg  <= hit_open_next;
            quiet_reg     <= quiet_next;
            charge_reg    <= charge_next;
            open_idx_reg  <= open_idx_next;
            first_idx_reg <= first_idx_next;
            skip_reg      <= skip_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance) begin
            out_vld_reg <= emit;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_cross_reg  <= cross_ext[IB-1:0];
            out_start_reg  <= start_ext[IB-1:0];
            out_length_reg <= len_ext[LB-1:0];
            out_charge_reg <= charge_next;
        end
    end

    assign m_valid       = out_vld_reg;
    assign m_cross_index = out_cross_reg;
    assign m_start_index = out_start_reg;
    assign m_length      = out_length_reg;
    assign m_charge      = out_charge_reg;

endmodule
